// ----- src/fffp_pkg.sv -----
// Shared constants, types and controller/datapath interface structs for the
// fixed-frame packet FIFO. No dependencies.
package fffp_pkg;

  localparam int unsigned FRAME_BYTES     = 10;
  localparam int unsigned ASM_DEPTH       = FRAME_BYTES - 1;
  localparam int unsigned ASM_CNT_W       = 4;
  localparam int unsigned DEF_QUEUE_DEPTH = 8;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LOW_W    = 64;
  localparam int unsigned HIGH_W   = 16;
  localparam int unsigned QCOUNT_W = 4;
  localparam int unsigned ENTRY_W  = LOW_W + HIGH_W;

  // result tdata: packet_low, packet_high, queued_count, padded to whole bytes
  localparam int unsigned OUT_DATA_BITS = LOW_W + HIGH_W + QCOUNT_W;
  localparam int unsigned OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W    = 3;

  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_POP     = 1'b1;

  typedef struct packed {
    logic take_byte;   // absorb rx byte, store or drop frame, load result
    logic pop_read;    // read head entry, advance read side
    logic pop_load;    // load result from read data
    logic pop_empty;   // load empty-pop result
  } fffp_cmd_t;

  typedef struct packed {
    logic empty;
  } fffp_status_t;

endpackage

// ----- src/fixed_frame_packet_fifo.sv -----
// Fixed-frame packet FIFO: 10-byte frame assembler feeding a ring of packets.
// Byte transaction and empty-pop results are valid the cycle after accept; a pop of
// a stored packet goes through the registered packet memory read, then the result
// register. One item at a time: no new item is accepted until the result is taken.
// Reset (synchronous, rst_n low) empties the queue and restarts assembly;
// packet memory contents are not cleared.
module fixed_frame_packet_fifo #(
  parameter int unsigned QUEUE_DEPTH = fffp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] rx_byte
  input  logic                                in_tuser,   // [0] op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [63:0] packet_low, [79:64] packet_high, [83:80] queued_count, [87:84] zero
  output logic [fffp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] frame_stored, [1] frame_dropped, [2] pop_valid
  output logic [fffp_pkg::OUT_USER_W-1:0]     out_tuser
);
  import fffp_pkg::*;

  fffp_cmd_t            cmd;
  fffp_status_t         status;
  logic                 frame_stored, frame_dropped, pop_valid;
  logic [LOW_W-1:0]     packet_low;
  logic [HIGH_W-1:0]    packet_high;
  logic [QCOUNT_W-1:0]  queued_count;

  fffp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  fffp_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_byte       (in_tdata),
    .cmd           (cmd),
    .status        (status),
    .frame_stored  (frame_stored),
    .frame_dropped (frame_dropped),
    .pop_valid     (pop_valid),
    .packet_low    (packet_low),
    .packet_high   (packet_high),
    .queued_count  (queued_count)
  );

  assign out_tdata = {{(OUT_DATA_W - OUT_DATA_BITS){1'b0}},
                      queued_count, packet_high, packet_low};
  assign out_tuser = {pop_valid, frame_dropped, frame_stored};

endmodule

// ----- src/fffp_ctrl.sv -----
// Controller state machine for the fixed-frame packet FIFO.
// Depends on fffp_pkg; drives commands into fffp_dp.
module fffp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_op,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  fffp_pkg::fffp_status_t status,
  output fffp_pkg::fffp_cmd_t    cmd
);
  import fffp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_RX_BYTE) begin
            cmd.take_byte = 1'b1;
            state_nxt     = S_OUT;
          end else if (status.empty) begin
            cmd.pop_empty = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            cmd.pop_read = 1'b1;
            state_nxt    = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/fffp_dp.sv -----
// Datapath for the fixed-frame packet FIFO: frame assembly registers, packet
// memory, pointers and result register. Depends on fffp_pkg; driven by fffp_ctrl.
module fffp_dp #(
  parameter int unsigned QUEUE_DEPTH = fffp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fffp_pkg::BYTE_W-1:0]         rx_byte,
  input  fffp_pkg::fffp_cmd_t                 cmd,
  output fffp_pkg::fffp_status_t              status,
  output logic                                frame_stored,
  output logic                                frame_dropped,
  output logic                                pop_valid,
  output logic [fffp_pkg::LOW_W-1:0]          packet_low,
  output logic [fffp_pkg::HIGH_W-1:0]         packet_high,
  output logic [fffp_pkg::QCOUNT_W-1:0]       queued_count
);
  import fffp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [BYTE_W-1:0]    asm_bytes_r [ASM_DEPTH];
  logic [ASM_CNT_W-1:0] asm_cnt_r;
  logic [ENTRY_W-1:0]   mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]   rd_data_r;
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic                 stored_r, dropped_r, valid_r;
  logic [LOW_W-1:0]     low_r;
  logic [HIGH_W-1:0]    high_r;
  logic [QCOUNT_W-1:0]  qcnt_r;

  logic                 frame_done, full, store;
  logic [LOW_W-1:0]     frame_low;
  logic [HIGH_W-1:0]    frame_high;
  logic [CNT_W+QCOUNT_W-1:0] cnt_ext;

  assign frame_done = (asm_cnt_r == ASM_CNT_W'(ASM_DEPTH));
  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign store      = cmd.take_byte && frame_done && !full;
  assign status.empty = (cnt_r == '0);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      frame_low[i*BYTE_W +: BYTE_W] = asm_bytes_r[i];
    end
    frame_high = {rx_byte, asm_bytes_r[ASM_DEPTH-1]};
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (store) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop_read) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // queued_count keeps the low bits of the fill level
  assign cnt_ext = {{QCOUNT_W{1'b0}}, cnt_nxt};

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_cnt_r <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.take_byte) begin
        asm_cnt_r <= frame_done ? '0 : asm_cnt_r + ASM_CNT_W'(1);
      end
      if (store) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (cmd.pop_read) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && !frame_done) begin
      asm_bytes_r[asm_cnt_r] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[wr_ptr_r] <= {frame_high, frame_low};
    end
    if (cmd.pop_read) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.take_byte || cmd.pop_empty) begin
      stored_r  <= store;
      dropped_r <= cmd.take_byte && frame_done && full;
      valid_r   <= 1'b0;
      low_r     <= '0;
      high_r    <= '0;
      qcnt_r    <= cnt_ext[QCOUNT_W-1:0];
    end else if (cmd.pop_load) begin
      stored_r  <= 1'b0;
      dropped_r <= 1'b0;
      valid_r   <= 1'b1;
      low_r     <= rd_data_r[LOW_W-1:0];
      high_r    <= rd_data_r[ENTRY_W-1:LOW_W];
      qcnt_r    <= cnt_ext[QCOUNT_W-1:0];
    end
  end

  assign frame_stored  = stored_r;
  assign frame_dropped = dropped_r;
  assign pop_valid     = valid_r;
  assign packet_low    = low_r;
  assign packet_high   = high_r;
  assign queued_count  = qcnt_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill level above queue depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_read |-> cnt_r != '0)
    else $error("pop read on empty queue");

  a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
    store |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("stored frame not counted");

  a_asm_range: assert property (@(posedge clk) disable iff (!rst_n)
    asm_cnt_r <= ASM_CNT_W'(ASM_DEPTH))
    else $error("assembly count out of range");
`endif

endmodule
